@@ src/dkwm_pkg.sv @@
// Shared types, register indexes and base decoding for the k-mer window minimizer.
`default_nettype none
package dkwm_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_KMER_LENGTH   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 8'd1;

   localparam logic [4:0] KMER_LENGTH_RESET   = 5'd15;
   localparam logic [6:0] WINDOW_LENGTH_RESET = 7'd10;

   localparam int COUNT_W = 32;
   localparam int VALUE_W = 32;

   typedef struct packed {
      logic       known;
      logic [1:0] fwd;
      logic [1:0] cmp;
   } code_type;

   typedef struct packed {
      logic shift;
      logic run;
      logic start;
   } scan_ctl_type;

   // forward C0 A1 T2 G3, complement A2 C3 G0 T1
   function automatic code_type base_code(input logic [7:0] b);
      code_type c;
      c = '{known: 1'b1, fwd: 2'd0, cmp: 2'd0};
      case (b)
         8'h41, 8'h61: begin c.fwd = 2'd1; c.cmp = 2'd2; end
         8'h43, 8'h63: begin c.fwd = 2'd0; c.cmp = 2'd3; end
         8'h47, 8'h67: begin c.fwd = 2'd3; c.cmp = 2'd0; end
         8'h54, 8'h74: begin c.fwd = 2'd2; c.cmp = 2'd1; end
         default: c.known = 1'b0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

@@ src/dna_kmer_window_minimizer_core.sv @@
// Top level of the DNA k-mer sliding-window minimizer.
// Takes one ASCII base per transfer and keeps forward and complement rolling k-mers
// in a shift line of WINDOW_MAX cells. A base that completes a window starts a scan
// in which the running minimum ripples from the oldest window cell to the newest, one
// cell per clock, so such a base holds the block for accept, a scan step per window
// cell and the result hand-off, which waits while the result register is full; a
// base that yields no result leaves the block ready. The result register lets the next
// base be accepted while a result still waits for its transfer. Configuration writes
// are taken in any cycle and act at once; change them only between items.
`default_nettype none
module dna_kmer_window_minimizer_core #(
   parameter int WINDOW_MAX = 64,
   parameter int KMER_MAX   = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [7:0]                         req_tdata,   // base[7:0]
   input  wire                                req_tlast,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [63:0]                        rsp_tdata,   // min_value[31:0], min_position[63:32]
   output logic [0:0]                         rsp_tuser,   // forward_strand[0]
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [dkwm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [dkwm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import dkwm_pkg::*;

   localparam int KMER_W = 2 * KMER_MAX;
   localparam int AGE_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int WCNT_W = $clog2(WINDOW_MAX + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type          state_ff, state_in;
   logic [4:0]         kmer_length_ff, kmer_length_in;
   logic [6:0]         window_length_ff, window_length_in;
   logic [KMER_W-1:0]  fwd_kmer_ff, fwd_kmer_in, cmp_kmer_ff, cmp_kmer_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] newest_ff, newest_in;
   logic [AGE_W-1:0]   w_last_ff, w_last_in;
   logic [AGE_W-1:0]   scan_cnt_ff, scan_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_fwd_ff, rsp_fwd_in;

   logic [4:0]         k_eff;
   logic [WCNT_W-1:0]  w_eff;
   logic [63:0]        mask_wide;
   logic [KMER_W-1:0]  mask, fwd_next, cmp_next;
   code_type           code;
   logic [COUNT_W-1:0] count_sat;
   logic               accept, push, emit, pick_fwd;
   logic [VALUE_W-1:0] pick_val;
   logic [AGE_W-1:0]   pick_age;
   scan_ctl_type       ctl;

   logic [KMER_W-1:0]  fwd_tap [WINDOW_MAX];
   logic [KMER_W-1:0]  cmp_tap [WINDOW_MAX];
   logic [KMER_W-1:0]  cf_val  [WINDOW_MAX];
   logic [AGE_W-1:0]   cf_age  [WINDOW_MAX];
   logic [KMER_W-1:0]  cc_val  [WINDOW_MAX];
   logic [AGE_W-1:0]   cc_age  [WINDOW_MAX];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (kmer_length_ff == 5'd0)               k_eff = 5'd1;
      else if (32'(kmer_length_ff) > KMER_MAX)  k_eff = 5'(KMER_MAX);
      else                                      k_eff = kmer_length_ff;

      if (window_length_ff == 7'd0)                w_eff = WCNT_W'(1);
      else if (32'(window_length_ff) > WINDOW_MAX) w_eff = WCNT_W'(WINDOW_MAX);
      else                                         w_eff = WCNT_W'(window_length_ff);

      mask_wide = (64'd1 << {k_eff, 1'b0}) - 64'd1;
      mask      = mask_wide[KMER_W-1:0];
      code      = base_code(req_tdata);
      fwd_next  = code.known ? (((fwd_kmer_ff << 2) | KMER_W'(code.fwd)) & mask) : mask;
      cmp_next  = code.known ? (((cmp_kmer_ff << 2) | KMER_W'(code.cmp)) & mask) : mask;
      count_sat = (count_ff == '1) ? count_ff : count_ff + 32'd1;
      push      = count_sat >= 32'(k_eff);
      emit      = 33'(count_sat) >= (33'(k_eff) + 33'(w_eff) - 33'd1);

      pick_fwd  = cf_val[0] < cc_val[0];
      pick_val  = pick_fwd ? 32'(cf_val[0]) : 32'(cc_val[0]);
      pick_age  = pick_fwd ? cf_age[0] : cc_age[0];

      ctl.shift = accept && push;
      ctl.run   = (state_ff == ST_SCAN);
      ctl.start = (state_ff == ST_SCAN) && (scan_cnt_ff == '0);
   end

   always_comb begin
      state_in         = state_ff;
      kmer_length_in   = kmer_length_ff;
      window_length_in = window_length_ff;
      fwd_kmer_in      = fwd_kmer_ff;
      cmp_kmer_in      = cmp_kmer_ff;
      count_in         = count_ff;
      newest_in        = newest_ff;
      w_last_in        = w_last_ff;
      scan_cnt_in      = scan_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      rsp_fwd_in       = rsp_fwd_ff;

      if (csr_valid) begin
         if (csr_index == CSR_KMER_LENGTH)   kmer_length_in   = csr_data[4:0];
         if (csr_index == CSR_WINDOW_LENGTH) window_length_in = csr_data[6:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fwd_kmer_in = req_tlast ? '0 : fwd_next;
               cmp_kmer_in = req_tlast ? '0 : cmp_next;
               count_in    = req_tlast ? '0 : count_sat;
               newest_in   = count_sat - 32'(k_eff);
               w_last_in   = AGE_W'(w_eff - WCNT_W'(1));
               scan_cnt_in = '0;
               if (emit) state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff == w_last_ff) state_in = ST_DONE;
            else scan_cnt_in = scan_cnt_ff + AGE_W'(1);
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {newest_ff - 32'(pick_age), pick_val};
               rsp_fwd_in   = pick_fwd;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         kmer_length_ff   <= KMER_LENGTH_RESET;
         window_length_ff <= WINDOW_LENGTH_RESET;
         fwd_kmer_ff      <= '0;
         cmp_kmer_ff      <= '0;
         count_ff         <= '0;
         scan_cnt_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         kmer_length_ff   <= kmer_length_in;
         window_length_ff <= window_length_in;
         fwd_kmer_ff      <= fwd_kmer_in;
         cmp_kmer_ff      <= cmp_kmer_in;
         count_ff         <= count_in;
         scan_cnt_ff      <= scan_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      newest_ff   <= newest_in;
      w_last_ff   <= w_last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_fwd_ff  <= rsp_fwd_in;
   end

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic [KMER_W-1:0] fwd_src, cmp_src, of_val, oc_val;
      logic [AGE_W-1:0]  of_age, oc_age;
      if (i == 0) begin : g_head
         assign fwd_src = fwd_next;
         assign cmp_src = cmp_next;
      end else begin : g_body
         assign fwd_src = fwd_tap[i-1];
         assign cmp_src = cmp_tap[i-1];
      end
      if (i == WINDOW_MAX - 1) begin : g_tail
         assign of_val = '0;
         assign of_age = '0;
         assign oc_val = '0;
         assign oc_age = '0;
      end else begin : g_link
         assign of_val = cf_val[i+1];
         assign of_age = cf_age[i+1];
         assign oc_val = cc_val[i+1];
         assign oc_age = cc_age[i+1];
      end
      dkwm_cell #(
         .KMER_W (KMER_W),
         .AGE_W  (AGE_W),
         .INDEX  (i)
      ) u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .w_last        (w_last_ff),
         .fwd_in        (fwd_src),
         .cmp_in        (cmp_src),
         .fwd_out       (fwd_tap[i]),
         .cmp_out       (cmp_tap[i]),
         .older_fwd_val (of_val),
         .older_fwd_age (of_age),
         .older_cmp_val (oc_val),
         .older_cmp_age (oc_age),
         .cand_fwd_val  (cf_val[i]),
         .cand_fwd_age  (cf_age[i]),
         .cand_cmp_val  (cc_val[i]),
         .cand_cmp_age  (cc_age[i])
      );
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_fwd_ff;

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_cnt_ff <= w_last_ff))
      else $error("scan counter ran past window end");

   a_done_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> ($past(state_ff) == ST_SCAN || $past(state_ff) == ST_DONE))
      else $error("result hand-off without a scan");

   a_emit_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> (state_ff == ST_SCAN && scan_cnt_ff == '0))
      else $error("full window did not start a scan");

endmodule
`default_nettype wire

@@ src/dkwm_cell.sv @@
// One window slot: holds a k-mer pair, shifts it on, and merges the running minimum.
`default_nettype none
module dkwm_cell #(
   parameter int KMER_W = 32,
   parameter int AGE_W  = 6,
   parameter int INDEX  = 0
) (
   input  wire                        clock,
   input  dkwm_pkg::scan_ctl_type     ctl,
   input  wire  [AGE_W-1:0]           w_last,
   input  wire  [KMER_W-1:0]          fwd_in,
   input  wire  [KMER_W-1:0]          cmp_in,
   output logic [KMER_W-1:0]          fwd_out,
   output logic [KMER_W-1:0]          cmp_out,
   input  wire  [KMER_W-1:0]          older_fwd_val,
   input  wire  [AGE_W-1:0]           older_fwd_age,
   input  wire  [KMER_W-1:0]          older_cmp_val,
   input  wire  [AGE_W-1:0]           older_cmp_age,
   output logic [KMER_W-1:0]          cand_fwd_val,
   output logic [AGE_W-1:0]           cand_fwd_age,
   output logic [KMER_W-1:0]          cand_cmp_val,
   output logic [AGE_W-1:0]           cand_cmp_age
);
   import dkwm_pkg::*;

   localparam logic [AGE_W-1:0] MY_AGE = AGE_W'(INDEX);

   logic [KMER_W-1:0] fwd_ff, cmp_ff;
   logic [KMER_W-1:0] cand_fwd_val_ff, cand_cmp_val_ff;
   logic [AGE_W-1:0]  cand_fwd_age_ff, cand_cmp_age_ff;
   logic [KMER_W-1:0] cand_fwd_val_in, cand_cmp_val_in;
   logic [AGE_W-1:0]  cand_fwd_age_in, cand_cmp_age_in;
   logic              start_here;

   // older entry wins ties
   always_comb begin
      start_here = ctl.start && (w_last == MY_AGE);
      if (start_here || (fwd_ff < older_fwd_val)) begin
         cand_fwd_val_in = fwd_ff;
         cand_fwd_age_in = MY_AGE;
      end else begin
         cand_fwd_val_in = older_fwd_val;
         cand_fwd_age_in = older_fwd_age;
      end
      if (start_here || (cmp_ff < older_cmp_val)) begin
         cand_cmp_val_in = cmp_ff;
         cand_cmp_age_in = MY_AGE;
      end else begin
         cand_cmp_val_in = older_cmp_val;
         cand_cmp_age_in = older_cmp_age;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         fwd_ff <= fwd_in;
         cmp_ff <= cmp_in;
      end
      if (ctl.run) begin
         cand_fwd_val_ff <= cand_fwd_val_in;
         cand_fwd_age_ff <= cand_fwd_age_in;
         cand_cmp_val_ff <= cand_cmp_val_in;
         cand_cmp_age_ff <= cand_cmp_age_in;
      end
   end

   assign fwd_out      = fwd_ff;
   assign cmp_out      = cmp_ff;
   assign cand_fwd_val = cand_fwd_val_ff;
   assign cand_fwd_age = cand_fwd_age_ff;
   assign cand_cmp_val = cand_cmp_val_ff;
   assign cand_cmp_age = cand_cmp_age_ff;

endmodule
`default_nettype wire
